// ----- rtl/hpbp_pkg.sv -----
`timescale 1ns / 1ps

package hpbp_pkg;

	localparam int COORD_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int SCALE_W   = 22;
	localparam int FRAC_UNIT = 30;
	localparam int UNIT_W    = FRAC_UNIT + 2;
	localparam int ROOT_W    = FRAC_UNIT + 1;
	localparam int SUM_W     = UNIT_W + 1;

	localparam logic [0:0] REG_BIS_SCALE = 1'b0;
	localparam logic [0:0] REG_NRM_SCALE = 1'b1;

	localparam logic [SCALE_W-1:0] BIS_SCALE_RST = SCALE_W'(65536);
	localparam logic [SCALE_W-1:0] NRM_SCALE_RST = '0;

	localparam logic signed [COORD_W+1:0] POS_MAX = {3'b000, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W+1:0] NEG_MIN = {3'b111, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_y;
		logic signed [COORD_W-1:0] first_z;
		logic signed [COORD_W-1:0] centre_x;
		logic signed [COORD_W-1:0] centre_y;
		logic signed [COORD_W-1:0] centre_z;
		logic signed [COORD_W-1:0] third_x;
		logic signed [COORD_W-1:0] third_y;
		logic signed [COORD_W-1:0] third_z;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] minus_x;
		logic signed [COORD_W-1:0] minus_y;
		logic signed [COORD_W-1:0] minus_z;
		logic signed [COORD_W-1:0] plus_x;
		logic signed [COORD_W-1:0] plus_y;
		logic signed [COORD_W-1:0] plus_z;
		logic                      degenerate;
	} result_t;

	typedef struct packed {
		logic [2:0][DIFF_W-1:0]  d1;
		logic [2:0][DIFF_W-1:0]  d3;
		logic [2:0][DIFF_W-1:0]  d13;
		logic [2:0][COORD_W-1:0] b;
	} diff_t;

	// round Q.60-style product down by 30 bits, nearest, ties away from zero
	function automatic logic signed [34:0] rnd_q30(input logic signed [63:0] x);
		logic [63:0] m;
		logic [33:0] r;
		m = x[63] ? 64'(-x) : 64'(x);
		r = 34'((m + (64'd1 << (FRAC_UNIT - 1))) >> FRAC_UNIT);
		return x[63] ? -$signed({1'b0, r}) : $signed({1'b0, r});
	endfunction

	function automatic logic [COORD_W-1:0] sat_coord(input logic signed [COORD_W+1:0] x);
		logic signed [COORD_W+1:0] y;
		y = x;
		if (x > POS_MAX) y = POS_MAX;
		if (x < NEG_MIN) y = NEG_MIN;
		return y[COORD_W-1:0];
	endfunction

endpackage

// ----- rtl/hpbp_norm.sv -----
`timescale 1ns / 1ps

module hpbp_norm #(
	parameter int VW     = 33,
	parameter int SIDE_W = 1
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_vld,
	input  logic [2:0][VW-1:0]                      in_vec,
	input  logic [SIDE_W-1:0]                       in_side,
	output logic                                    out_vld,
	output logic [2:0][hpbp_pkg::UNIT_W-1:0]        out_unit,
	output logic                                    out_ok,
	output logic [SIDE_W-1:0]                       out_side
);

	localparam int FR  = hpbp_pkg::FRAC_UNIT;
	localparam int UW  = hpbp_pkg::UNIT_W;
	localparam int RT  = hpbp_pkg::ROOT_W;
	localparam int L2W = 2 * RT;
	localparam int RW  = RT + 2;
	localparam int NW  = 2 * FR + 1;

	// magnitude and sign
	logic              vld1_q;
	logic [2:0][VW-1:0] mag1_q;
	logic [2:0]        sgn1_q;
	logic [SIDE_W-1:0] side1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld1_q <= 1'b0;
		end else begin
			vld1_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag1_q[i] <= in_vec[i][VW-1] ? VW'(-in_vec[i]) : in_vec[i];
			sgn1_q[i] <= in_vec[i][VW-1];
		end
		side1_q <= in_side;
	end

	// bit length of the largest magnitude
	logic              vld2_q;
	logic [2:0][VW-1:0] mag2_q;
	logic [2:0]        sgn2_q;
	logic              nz2_q;
	logic [6:0]        bits2_q;
	logic [SIDE_W-1:0] side2_q;
	logic [VW-1:0]     or_w;
	logic [6:0]        bits_w;

	always_comb begin
		or_w = mag1_q[0] | mag1_q[1] | mag1_q[2];
		bits_w = '0;
		for (int i = 0; i < VW; i++) begin
			if (or_w[i]) bits_w = 7'(i + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld2_q <= 1'b0;
		end else begin
			vld2_q <= vld1_q;
		end
	end

	always_ff @(posedge clk) begin
		mag2_q  <= mag1_q;
		sgn2_q  <= sgn1_q;
		nz2_q   <= |or_w;
		bits2_q <= bits_w;
		side2_q <= side1_q;
	end

	// shift so the top magnitude lands in [2^29, 2^30)
	logic              vld3_q;
	logic [2:0][FR-1:0] m3_q;
	logic [2:0]        sgn3_q;
	logic              nz3_q;
	logic [SIDE_W-1:0] side3_q;
	logic [VW+FR-1:0]  wide_w [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide_w[i] = {{FR{1'b0}}, mag2_q[i]};
			if (bits2_q > 7'(FR)) wide_w[i] = wide_w[i] >> (bits2_q - 7'(FR));
			else wide_w[i] = wide_w[i] << (7'(FR) - bits2_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld3_q <= 1'b0;
		end else begin
			vld3_q <= vld2_q;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) m3_q[i] <= wide_w[i][FR-1:0];
		sgn3_q  <= sgn2_q;
		nz3_q   <= nz2_q;
		side3_q <= side2_q;
	end

	// squares
	logic                vld4_q;
	logic [2:0][2*FR-1:0] sq4_q;
	logic [2:0][FR-1:0]  m4_q;
	logic [2:0]          sgn4_q;
	logic                nz4_q;
	logic [SIDE_W-1:0]   side4_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld4_q <= 1'b0;
		end else begin
			vld4_q <= vld3_q;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) sq4_q[i] <= m3_q[i] * m3_q[i];
		m4_q    <= m3_q;
		sgn4_q  <= sgn3_q;
		nz4_q   <= nz3_q;
		side4_q <= side3_q;
	end

	// square root, two radicand bits per stage
	logic                sq_vld  [RT+1];
	logic [L2W-1:0]      sq_n    [RT+1];
	logic [RW-1:0]       sq_rem  [RT+1];
	logic [RT-1:0]       sq_root [RT+1];
	logic [2:0][FR-1:0]  sq_m    [RT+1];
	logic [2:0]          sq_sgn  [RT+1];
	logic                sq_nz   [RT+1];
	logic [SIDE_W-1:0]   sq_side [RT+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld[0] <= 1'b0;
		end else begin
			sq_vld[0] <= vld4_q;
		end
	end

	always_ff @(posedge clk) begin
		sq_n[0]    <= L2W'(sq4_q[0]) + L2W'(sq4_q[1]) + L2W'(sq4_q[2]);
		sq_rem[0]  <= '0;
		sq_root[0] <= '0;
		sq_m[0]    <= m4_q;
		sq_sgn[0]  <= sgn4_q;
		sq_nz[0]   <= nz4_q;
		sq_side[0] <= side4_q;
	end

	for (genvar k = 0; k < RT; k++) begin : g_sqrt
		logic [RW+1:0] r2_w;
		logic [RW+1:0] t_w;
		logic          geq_w;

		assign r2_w  = {sq_rem[k], sq_n[k][L2W-1 -: 2]};
		assign t_w   = {2'b00, sq_root[k], 2'b01};
		assign geq_w = r2_w >= t_w;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld[k+1] <= 1'b0;
			end else begin
				sq_vld[k+1] <= sq_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			sq_rem[k+1]  <= geq_w ? RW'(r2_w - t_w) : RW'(r2_w);
			sq_root[k+1] <= {sq_root[k][RT-2:0], geq_w};
			sq_n[k+1]    <= sq_n[k] << 2;
			sq_m[k+1]    <= sq_m[k];
			sq_sgn[k+1]  <= sq_sgn[k];
			sq_nz[k+1]   <= sq_nz[k];
			sq_side[k+1] <= sq_side[k];
		end
	end

	// divide each component by the length, one quotient bit per stage
	logic                dv_vld  [RT+1];
	logic [2:0][RT-1:0]  dv_rem  [RT+1];
	logic [2:0][RT-1:0]  dv_low  [RT+1];
	logic [2:0][RT-1:0]  dv_q    [RT+1];
	logic [RT-1:0]       dv_d    [RT+1];
	logic [2:0]          dv_sgn  [RT+1];
	logic                dv_nz   [RT+1];
	logic [SIDE_W-1:0]   dv_side [RT+1];
	logic [NW-1:0]       num_w   [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_w[i] = {1'b0, sq_m[RT][i], {FR{1'b0}}} + NW'(sq_root[RT] >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld[0] <= 1'b0;
		end else begin
			dv_vld[0] <= sq_vld[RT];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dv_rem[0][i] <= {1'b0, num_w[i][NW-1 -: FR]};
			dv_low[0][i] <= num_w[i][RT-1:0];
			dv_q[0][i]   <= '0;
		end
		dv_d[0]    <= sq_root[RT];
		dv_sgn[0]  <= sq_sgn[RT];
		dv_nz[0]   <= sq_nz[RT];
		dv_side[0] <= sq_side[RT];
	end

	for (genvar k = 0; k < RT; k++) begin : g_div
		logic [RT:0] r_w   [3];
		logic [2:0]  geq_w;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				r_w[i]   = {dv_rem[k][i], dv_low[k][i][RT-1]};
				geq_w[i] = r_w[i] >= {1'b0, dv_d[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[k+1] <= 1'b0;
			end else begin
				dv_vld[k+1] <= dv_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem[k+1][i] <= geq_w[i] ? RT'(r_w[i] - {1'b0, dv_d[k]}) : r_w[i][RT-1:0];
				dv_low[k+1][i] <= dv_low[k][i] << 1;
				dv_q[k+1][i]   <= {dv_q[k][i][RT-2:0], geq_w[i]};
			end
			dv_d[k+1]    <= dv_d[k];
			dv_sgn[k+1]  <= dv_sgn[k];
			dv_nz[k+1]   <= dv_nz[k];
			dv_side[k+1] <= dv_side[k];
		end
	end

	// restore signs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= dv_vld[RT];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			out_unit[i] <= dv_sgn[RT][i] ? UW'(-{1'b0, dv_q[RT][i]}) : UW'({1'b0, dv_q[RT][i]});
		end
		out_ok   <= dv_nz[RT];
		out_side <= dv_side[RT];
	end

endmodule

// ----- rtl/hpbp_front.sv -----
`timescale 1ns / 1ps

module hpbp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  hpbp_pkg::item_t item,
	output logic            vld_s1,
	output hpbp_pkg::diff_t diff_s1
);

	localparam int DW = hpbp_pkg::DIFF_W;

	logic [2:0][hpbp_pkg::COORD_W-1:0] a_w, b_w, c_w;

	assign a_w = {item.first_z, item.first_y, item.first_x};
	assign b_w = {item.centre_z, item.centre_y, item.centre_x};
	assign c_w = {item.third_z, item.third_y, item.third_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	// take the three differences exactly, one bit wider than a coordinate
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			diff_s1.d1[i]  <= DW'($signed(b_w[i])) - DW'($signed(a_w[i]));
			diff_s1.d3[i]  <= DW'($signed(b_w[i])) - DW'($signed(c_w[i]));
			diff_s1.d13[i] <= DW'($signed(c_w[i])) - DW'($signed(a_w[i]));
		end
		diff_s1.b <= b_w;
	end

endmodule

// ----- rtl/hpbp_fifo.sv -----
`timescale 1ns / 1ps

module hpbp_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hpbp_pkg::diff_t push_data,
	output logic            pop,
	output hpbp_pkg::diff_t pop_data,
	output logic            full
);

	logic [1:0]      cnt_q;
	logic            wr_q;
	logic            rd_q;
	hpbp_pkg::diff_t mem_q [2];

	// back end never stalls: drain a beat whenever one is held
	assign pop      = cnt_q != 2'd0;
	assign pop_data = mem_q[rd_q];
	assign full     = cnt_q == 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

// ----- rtl/hpbp_back.sv -----
`timescale 1ns / 1ps

module hpbp_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  hpbp_pkg::diff_t                   in_data,
	input  logic [hpbp_pkg::SCALE_W-1:0]      bis_scale,
	input  logic [hpbp_pkg::SCALE_W-1:0]      nrm_scale,
	output logic                              out_vld,
	output hpbp_pkg::result_t                 out_data
);

	localparam int CW  = hpbp_pkg::COORD_W;
	localparam int UW  = hpbp_pkg::UNIT_W;
	localparam int SW  = hpbp_pkg::SUM_W;
	localparam int BW  = 3 * CW;
	localparam int U3W = 3 * UW;
	localparam int S2W = 1 + U3W + BW;

	// first level: three unit vectors in parallel
	logic                  n1_vld;
	logic [2:0][UW-1:0]    u1, u3, u13;
	logic                  ok1, ok3, ok13;
	logic [BW-1:0]         b_n1;

	hpbp_norm #(.VW(hpbp_pkg::DIFF_W), .SIDE_W(BW)) u_norm_d1 (
		.clk, .arst_n,
		.in_vld(in_vld), .in_vec(in_data.d1), .in_side(in_data.b),
		.out_vld(n1_vld), .out_unit(u1), .out_ok(ok1), .out_side(b_n1)
	);

	hpbp_norm #(.VW(hpbp_pkg::DIFF_W), .SIDE_W(1)) u_norm_d3 (
		.clk, .arst_n,
		.in_vld(in_vld), .in_vec(in_data.d3), .in_side(1'b0),
		.out_vld(), .out_unit(u3), .out_ok(ok3), .out_side()
	);

	hpbp_norm #(.VW(hpbp_pkg::DIFF_W), .SIDE_W(1)) u_norm_d13 (
		.clk, .arst_n,
		.in_vld(in_vld), .in_vec(in_data.d13), .in_side(1'b0),
		.out_vld(), .out_unit(u13), .out_ok(ok13), .out_side()
	);

	// bisector sum; halving is dropped since it normalizes away
	logic               vld_s1;
	logic [2:0][SW-1:0] sum_s1;
	logic [S2W-1:0]     side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= n1_vld;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sum_s1[i] <= SW'($signed(u1[i])) + SW'($signed(u3[i]));
		end
		side_s1 <= {ok1 && ok3 && ok13, u13, b_n1};
	end

	logic               n2_vld;
	logic [2:0][UW-1:0] bis;
	logic               ok2;
	logic [S2W-1:0]     side_n2;

	hpbp_norm #(.VW(SW), .SIDE_W(S2W)) u_norm_bis (
		.clk, .arst_n,
		.in_vld(vld_s1), .in_vec(sum_s1), .in_side(side_s1),
		.out_vld(n2_vld), .out_unit(bis), .out_ok(ok2), .out_side(side_n2)
	);

	logic [2:0][UW-1:0] u13_n2;
	logic [BW-1:0]      b_n2;

	assign u13_n2 = side_n2[BW +: U3W];
	assign b_n2   = side_n2[BW-1:0];

	// cross product u13 x bisector at Q4.60
	logic                   vld_s2;
	logic signed [63:0]     prod_s2 [6];
	logic [2:0][UW-1:0]     bis_s2;
	logic [BW-1:0]          b_s2;
	logic                   ok_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= n2_vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2[0] <= $signed(u13_n2[1]) * $signed(bis[2]);
		prod_s2[1] <= $signed(u13_n2[2]) * $signed(bis[1]);
		prod_s2[2] <= $signed(u13_n2[2]) * $signed(bis[0]);
		prod_s2[3] <= $signed(u13_n2[0]) * $signed(bis[2]);
		prod_s2[4] <= $signed(u13_n2[0]) * $signed(bis[1]);
		prod_s2[5] <= $signed(u13_n2[1]) * $signed(bis[0]);
		bis_s2 <= bis;
		b_s2   <= b_n2;
		ok_s2  <= ok2 && side_n2[S2W-1];
	end

	logic               vld_s3;
	logic signed [63:0] cr_s3 [3];
	logic [2:0][UW-1:0] bis_s3;
	logic [BW-1:0]      b_s3;
	logic               ok_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) cr_s3[i] <= prod_s2[2*i] - prod_s2[2*i+1];
		bis_s3 <= bis_s2;
		b_s3   <= b_s2;
		ok_s3  <= ok_s2;
	end

	// round the normal back to Q2.30
	logic               vld_s4;
	logic signed [33:0] nrm_s4 [3];
	logic [2:0][UW-1:0] bis_s4;
	logic [BW-1:0]      b_s4;
	logic               ok_s4;
	logic signed [34:0] nrm_w  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) nrm_w[i] = hpbp_pkg::rnd_q30(cr_s3[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) nrm_s4[i] <= nrm_w[i][33:0];
		bis_s4 <= bis_s3;
		b_s4   <= b_s3;
		ok_s4  <= ok_s3;
	end

	// scale both directions at Q.46
	logic               vld_s5;
	logic signed [57:0] along_s5 [3];
	logic signed [57:0] side_s5  [3];
	logic [BW-1:0]      b_s5;
	logic               ok_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			along_s5[i] <= $signed({1'b0, bis_scale}) * $signed(bis_s4[i]);
			side_s5[i]  <= $signed({1'b0, nrm_scale}) * nrm_s4[i];
		end
		b_s5  <= b_s4;
		ok_s5 <= ok_s4;
	end

	// offsets rounded to Q.16
	logic               vld_s6;
	logic signed [27:0] offm_s6 [3];
	logic signed [27:0] offp_s6 [3];
	logic [BW-1:0]      b_s6;
	logic               ok_s6;
	logic signed [34:0] offm_w [3];
	logic signed [34:0] offp_w [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			offm_w[i] = hpbp_pkg::rnd_q30(64'(along_s5[i] - side_s5[i]));
			offp_w[i] = hpbp_pkg::rnd_q30(64'(along_s5[i] + side_s5[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			offm_s6[i] <= offm_w[i][27:0];
			offp_s6[i] <= offp_w[i][27:0];
		end
		b_s6  <= b_s5;
		ok_s6 <= ok_s5;
	end

	// add to the centre, saturate, zero everything on a degenerate triple
	logic [2:0][CW-1:0] b3_w;
	logic [CW-1:0]      pm_w [3];
	logic [CW-1:0]      pp_w [3];

	assign b3_w = b_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pm_w[i] = ok_s6 ? hpbp_pkg::sat_coord((CW+2)'($signed(b3_w[i]))
				+ (CW+2)'(offm_s6[i])) : '0;
			pp_w[i] = ok_s6 ? hpbp_pkg::sat_coord((CW+2)'($signed(b3_w[i]))
				+ (CW+2)'(offp_s6[i])) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		out_data.minus_x    <= pm_w[0];
		out_data.minus_y    <= pm_w[1];
		out_data.minus_z    <= pm_w[2];
		out_data.plus_x     <= pp_w[0];
		out_data.plus_y     <= pp_w[1];
		out_data.plus_z     <= pp_w[2];
		out_data.degenerate <= !ok_s6;
	end

endmodule

// ----- rtl/hydrogen_pair_bisector_placement_core.sv -----
`timescale 1ns / 1ps

// Places two hydrogens on a central atom from its two heavy neighbours.
// Input channel: raise start with an item (first, centre and third atom
// coordinates, signed Q15.16); the beat is taken on a rising edge where
// start is high and busy is low. busy stays low in normal operation, so a
// new triple may be offered every cycle.
// Result channel: done is high for exactly one cycle with the two
// positions and the degenerate flag on result. The receiver cannot stall;
// take the beat in that cycle or lose it.
// The result path runs through two chained normalizers, each a 31-stage
// square root followed by a 31-stage divider. Throughput is one item per
// cycle; all stages are fully pipelined.
// Configuration: cfg_we writes cfg_data into register cfg_idx (bisector
// scale, then normal scale, unsigned Q6.16). Write only while no item is
// in flight; the scales are read live by the back end.
// Reset clears the pipeline valids, the queue and sets the scales to 1.0
// and 0.0. No clearing pass is needed.
module hydrogen_pair_bisector_placement_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  hpbp_pkg::item_t               item,
	output logic                          done,
	output hpbp_pkg::result_t             result,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_idx,
	input  logic [hpbp_pkg::SCALE_W-1:0]  cfg_data
);

	// scale registers
	logic [hpbp_pkg::SCALE_W-1:0] bis_scale_q;
	logic [hpbp_pkg::SCALE_W-1:0] nrm_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bis_scale_q <= hpbp_pkg::BIS_SCALE_RST;
			nrm_scale_q <= hpbp_pkg::NRM_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				hpbp_pkg::REG_BIS_SCALE: bis_scale_q <= cfg_data;
				hpbp_pkg::REG_NRM_SCALE: nrm_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: accept the beat and form the exact differences
	logic            front_vld;
	hpbp_pkg::diff_t front_diff;

	hpbp_front u_front (
		.clk, .arst_n,
		.start(start), .busy(busy), .item(item),
		.vld_s1(front_vld), .diff_s1(front_diff)
	);

	// short queue decoupling front from back
	logic            q_pop;
	hpbp_pkg::diff_t q_data;

	hpbp_fifo u_fifo (
		.clk, .arst_n,
		.push(front_vld), .push_data(front_diff),
		.pop(q_pop), .pop_data(q_data), .full(busy)
	);

	// back: normalize, bisect, cross, scale and place
	hpbp_back u_back (
		.clk, .arst_n,
		.in_vld(q_pop), .in_data(q_data),
		.bis_scale(bis_scale_q), .nrm_scale(nrm_scale_q),
		.out_vld(done), .out_data(result)
	);

	// queue drains every cycle, so it must never back up
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("queue filled up");

	// a degenerate triple must give all-zero positions
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.degenerate |-> result.minus_x == 0 && result.minus_y == 0 &&
		result.minus_z == 0 && result.plus_x == 0 && result.plus_y == 0 &&
		result.plus_z == 0)
		else $error("degenerate result carries nonzero position");

	// an accepted beat reaches the queue on the next edge
	a_front_push: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> front_vld)
		else $error("accepted beat not pushed");

endmodule
